// File: rtl/core/hbsd_pkg.sv
// Package for the bit-serial code tree decoder: sizes, operation and error
// codes, node entry and result word layouts.
// No dependencies.
`default_nettype none

package hbsd_pkg;

  localparam int MAX_NODES    = 512;
  localparam int NODE_AW      = $clog2(MAX_NODES);
  localparam int USED_W       = NODE_AW + 1;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int CNT_W        = 6;
  localparam int BYTE_BITS    = 8;
  localparam int SYM_W        = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DECODE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_MISSING = 2'd2,
    ERR_PREFIX  = 2'd3
  } err_t;

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [SYM_W-1:0]   sym;
    logic               leaf;
  } node_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    err_t             error_code;
    logic             last_of_item;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/hbsd_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; field widths follow the block's item layout.
`default_nettype none

interface hbsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  symbol_value;
  logic [31:0] code_word;
  logic [5:0]  code_length;
  logic [7:0]  data_byte;
  logic [3:0]  valid_bits;

  modport source (output valid, operation, symbol_value, code_word, code_length,
                  data_byte, valid_bits, input ready);
  modport sink (input valid, operation, symbol_value, code_word, code_length,
                data_byte, valid_bits, output ready);
endinterface

interface hbsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic [1:0] error_code;
  logic       last_of_item;

  modport source (output valid, symbol, symbol_valid, error_code, last_of_item,
                  input ready);
  modport sink (input valid, symbol, symbol_valid, error_code, last_of_item,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/hbsd_out_stage.sv
// Output register for result words: holds one word until the receiver takes it.
// Depends on hbsd_pkg and hbsd_if.
`default_nettype none

module hbsd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire hbsd_pkg::result_t push_res,
  output logic                  slot_free,
  hbsd_out_if.source            out_port
);

  logic              valid_r;
  logic              valid_nxt;
  hbsd_pkg::result_t res_r;

  assign slot_free = !valid_r || out_port.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_port.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: load on push only
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= push_res;
    end
  end

  assign out_port.valid        = valid_r;
  assign out_port.symbol       = res_r.symbol;
  assign out_port.symbol_valid = res_r.symbol_valid;
  assign out_port.error_code   = res_r.error_code;
  assign out_port.last_of_item = res_r.last_of_item;

endmodule

`default_nettype wire

// File: rtl/core/huffman_bit_serial_decoder.sv
// Top level of the bit-serial code tree decoder: node store, walk sequencer.
// Depends on hbsd_pkg, hbsd_if and hbsd_out_stage.
`default_nettype none

// Usage
//   in_port (sink) takes one word per item: clear the tree, load one code entry
//   (symbol, code bits, length) or decode one byte (data, count of valid low bits).
//   out_port (source) gives result words; the final word of each item carries
//   last_of_item. A clear or load gives one word, a decode gives one word per
//   symbol found, one word for a missing child, or one empty word.
//   Items are taken one at a time: in_port.ready is high only while the walker
//   is free. Reserved operation codes are taken and dropped without a result.
// Walk
//   The node store is a single memory with a registered read port, so each
//   tree step passes through a read state and then a look state. Bits are fed
//   MSB first from a shift register after an alignment pass over the unused bits.
//   A load stops early on an error, and a decode stops early on a missing child.
// Reset
//   Synchronous, active low. The cycle after reset writes an empty root, and
//   the tree then holds only the root. Node entries beyond the root are written
//   as they are taken into use, so no clearing pass runs over the store.
// Stall: a stalled receiver holds the output register; the walker waits at its
//   next result word until the register frees, and the tree position is kept.

module huffman_bit_serial_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hbsd_in_if.sink    in_port,
  hbsd_out_if.source out_port
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ALIGN = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_LLK   = 8'b0001_0000,
    S_LNEW  = 8'b0010_0000,
    S_DLK   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  localparam int AW = hbsd_pkg::NODE_AW;
  localparam int UW = hbsd_pkg::USED_W;
  localparam int CW = hbsd_pkg::CODE_W;
  localparam int NW = hbsd_pkg::CNT_W;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        node_r, node_nxt;
  logic [UW-1:0]        used_r, used_nxt;
  logic [AW-1:0]        walk_r, walk_nxt;
  logic [CW-1:0]        sh_r, sh_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        pad_r, pad_nxt;
  logic                 mode_r, mode_nxt;      // 1: load walk, 0: decode walk
  logic                 arrived_r, arrived_nxt; // node reached through a bit
  logic [hbsd_pkg::SYM_W-1:0] sym_r, sym_nxt;
  hbsd_pkg::result_t    pend_r, pend_nxt;
  logic                 pend_vld_r, pend_vld_nxt;

  // node store
  hbsd_pkg::node_t      mem [hbsd_pkg::MAX_NODES];
  hbsd_pkg::node_t      q_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  hbsd_pkg::node_t      mem_wd;
  logic                 rd_en;

  // result path
  logic                 push;
  hbsd_pkg::result_t    push_res;
  logic                 slot_free;
  logic                 emit_ok;

  // input decode
  hbsd_pkg::op_t        op;
  logic [NW-1:0]        len_sat;
  logic [3:0]           nb_sat;
  logic [AW-1:0]        start_node;

  // tree step
  logic                 cur_bit;
  logic [AW-1:0]        child;
  logic                 child_missing;
  logic                 tree_full;

  assign op         = hbsd_pkg::op_t'(in_port.operation);
  assign len_sat    = (in_port.code_length > NW'(hbsd_pkg::MAX_CODE_LEN)) ?
                      NW'(hbsd_pkg::MAX_CODE_LEN) : in_port.code_length;
  assign nb_sat     = (in_port.valid_bits > 4'(hbsd_pkg::BYTE_BITS)) ?
                      4'(hbsd_pkg::BYTE_BITS) : in_port.valid_bits;
  assign start_node = ({1'b0, walk_r} >= used_r) ? '0 : walk_r;

  assign cur_bit       = sh_r[CW-1];
  assign child         = cur_bit ? q_r.right : q_r.left;
  assign child_missing = (child == '0) || ({1'b0, child} >= used_r);
  assign tree_full     = (used_r == UW'(hbsd_pkg::MAX_NODES));

  // a new result may replace the pending one once the old one can leave
  assign emit_ok = !pend_vld_r || slot_free;

  assign in_port.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    node_nxt     = node_r;
    used_nxt     = used_r;
    walk_nxt     = walk_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    pad_nxt      = pad_r;
    mode_nxt     = mode_r;
    arrived_nxt  = arrived_r;
    sym_nxt      = sym_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    mem_we       = 1'b0;
    mem_wa       = node_r;
    mem_wd       = q_r;
    rd_en        = 1'b0;
    push         = 1'b0;
    push_res     = pend_r;

    case (state_r)
      S_INIT: begin
        // write an empty root
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = '0;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_port.valid) begin
          case (op)
            hbsd_pkg::OP_CLEAR: begin
              mem_we       = 1'b1;
              mem_wa       = '0;
              mem_wd       = '0;
              used_nxt     = UW'(1);
              walk_nxt     = '0;
              pend_nxt     = '0;
              pend_vld_nxt = 1'b1;
              state_nxt    = S_FIN;
            end
            hbsd_pkg::OP_LOAD: begin
              mode_nxt = 1'b1;
              node_nxt = '0;
              sym_nxt  = in_port.symbol_value;
              sh_nxt   = in_port.code_word;
              cnt_nxt  = len_sat;
              pad_nxt  = NW'(CW) - len_sat;
              if (len_sat == '0) begin
                pend_nxt            = '0;
                pend_nxt.error_code = hbsd_pkg::ERR_PREFIX;
                pend_vld_nxt        = 1'b1;
                state_nxt           = S_FIN;
              end else begin
                state_nxt = S_ALIGN;
              end
            end
            hbsd_pkg::OP_DECODE: begin
              mode_nxt     = 1'b0;
              node_nxt     = start_node;
              arrived_nxt  = 1'b0;
              pend_vld_nxt = 1'b0;
              sh_nxt       = {in_port.data_byte, (CW - hbsd_pkg::BYTE_BITS)'(0)};
              cnt_nxt      = {(NW - 4)'(0), nb_sat};
              pad_nxt      = NW'(hbsd_pkg::BYTE_BITS) - {(NW - 4)'(0), nb_sat};
              if (nb_sat == '0) begin
                walk_nxt  = start_node;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_ALIGN;
              end
            end
            default: begin
              // reserved code: drop the word
            end
          endcase
        end
      end

      S_ALIGN: begin
        // advance the shift register until the first code bit sits at the top
        if (pad_r != '0) begin
          sh_nxt  = {sh_r[CW-2:0], 1'b0};
          pad_nxt = pad_r - NW'(1);
        end else begin
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = mode_r ? S_LLK : S_DLK;
      end

      S_LLK: begin
        pend_nxt     = '0;
        pend_vld_nxt = 1'b1;
        if (cnt_r == '0) begin
          // final node: must have no children, then becomes a leaf
          if ((q_r.left != '0) || (q_r.right != '0)) begin
            pend_nxt.error_code = hbsd_pkg::ERR_PREFIX;
          end else begin
            mem_we      = 1'b1;
            mem_wd.leaf = 1'b1;
            mem_wd.sym  = sym_r;
          end
          state_nxt = S_FIN;
        end else if (q_r.leaf) begin
          pend_nxt.error_code = hbsd_pkg::ERR_PREFIX;
          state_nxt           = S_FIN;
        end else if (child_missing) begin
          if (tree_full) begin
            pend_nxt.error_code = hbsd_pkg::ERR_FULL;
            state_nxt           = S_FIN;
          end else begin
            // link a fresh node into the parent, initialise it next cycle
            pend_vld_nxt = pend_vld_r;
            pend_nxt     = pend_r;
            mem_we       = 1'b1;
            if (cur_bit) begin
              mem_wd.right = used_r[AW-1:0];
            end else begin
              mem_wd.left = used_r[AW-1:0];
            end
            node_nxt  = used_r[AW-1:0];
            used_nxt  = used_r + UW'(1);
            state_nxt = S_LNEW;
          end
        end else begin
          pend_vld_nxt = pend_vld_r;
          pend_nxt     = pend_r;
          node_nxt     = child;
          sh_nxt       = {sh_r[CW-2:0], 1'b0};
          cnt_nxt      = cnt_r - NW'(1);
          state_nxt    = S_RD;
        end
      end

      S_LNEW: begin
        mem_we    = 1'b1;
        mem_wd    = '0;
        sh_nxt    = {sh_r[CW-2:0], 1'b0};
        cnt_nxt   = cnt_r - NW'(1);
        state_nxt = S_RD;
      end

      S_DLK: begin
        if (arrived_r && q_r.leaf) begin
          if (emit_ok) begin
            push                  = pend_vld_r;
            pend_nxt              = '0;
            pend_nxt.symbol       = q_r.sym;
            pend_nxt.symbol_valid = 1'b1;
            pend_vld_nxt          = 1'b1;
            node_nxt              = '0;
            arrived_nxt           = 1'b0;
            if (cnt_r == '0) begin
              walk_nxt  = '0;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RD;
            end
          end
        end else if (cnt_r == '0) begin
          walk_nxt  = node_r;
          state_nxt = S_FIN;
        end else if (child_missing) begin
          // drop the rest of the byte and return to the root
          if (emit_ok) begin
            push                = pend_vld_r;
            pend_nxt            = '0;
            pend_nxt.error_code = hbsd_pkg::ERR_MISSING;
            pend_vld_nxt        = 1'b1;
            node_nxt            = '0;
            walk_nxt            = '0;
            state_nxt           = S_FIN;
          end
        end else begin
          node_nxt    = child;
          arrived_nxt = 1'b1;
          sh_nxt      = {sh_r[CW-2:0], 1'b0};
          cnt_nxt     = cnt_r - NW'(1);
          state_nxt   = S_RD;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          push                  = 1'b1;
          push_res              = pend_vld_r ? pend_r : '0;
          push_res.last_of_item = 1'b1;
          pend_vld_nxt          = 1'b0;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      used_r     <= UW'(1);
      walk_r     <= '0;
      pend_vld_r <= 1'b0;
      mode_r     <= 1'b0;
      arrived_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      walk_r     <= walk_nxt;
      pend_vld_r <= pend_vld_nxt;
      mode_r     <= mode_nxt;
      arrived_r  <= arrived_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    pad_r  <= pad_nxt;
    sym_r  <= sym_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      q_r <= mem[node_r];
    end
  end

  hbsd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .slot_free(slot_free),
    .out_port (out_port)
  );

endmodule

`default_nettype wire

// File: rtl/core/hbsd_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on hbsd_pkg and huffman_bit_serial_decoder.
`default_nettype none

module hbsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_symbol,
  input wire logic       out_symbol_valid,
  input wire logic [1:0] out_error_code,
  input wire logic       out_last_of_item
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_symbol, out_symbol_valid, out_error_code, out_last_of_item}))
    else $error("result word changed while stalled");

  a_sym_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |->
      out_error_code == hbsd_pkg::ERR_OK)
    else $error("symbol word carries an error");

  a_empty_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_symbol == 8'd0)
    else $error("non-symbol word carries a symbol value");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == hbsd_pkg::ERR_FULL ||
                  out_error_code == hbsd_pkg::ERR_MISSING ||
                  out_error_code == hbsd_pkg::ERR_PREFIX) |-> out_last_of_item)
    else $error("error word is not the last of its item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind huffman_bit_serial_decoder hbsd_checker u_hbsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_port.valid),
  .out_ready       (out_port.ready),
  .out_symbol      (out_port.symbol),
  .out_symbol_valid(out_port.symbol_valid),
  .out_error_code  (out_port.error_code),
  .out_last_of_item(out_port.last_of_item)
);

`default_nettype wire

// File: verif/huffman_bit_serial_decoder_tb.sv
// Self-checking testbench for huffman_bit_serial_decoder: a shadow code tree
// predicts every result word, which is checked against the out_port stream.
// Depends on hbsd_pkg, hbsd_if and the decoder RTL.

module huffman_bit_serial_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input word as the test builds it; unused fields carry junk.
  typedef struct {
    hbsd_pkg::op_t op;
    logic [7:0]    sym;
    logic [31:0]   code;
    logic [5:0]    len;
    logic [7:0]    data;
    logic [3:0]    nbits;
  } tree_cmd_t;

  // Worst load walks 32 bits with a new node per bit; allow for that at the end.
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hbsd_in_if  in_port ();
  hbsd_out_if out_port ();

  huffman_bit_serial_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .out_port (out_port)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the node store and walker state.
  logic [hbsd_pkg::NODE_AW-1:0] shadow_left  [hbsd_pkg::MAX_NODES];
  logic [hbsd_pkg::NODE_AW-1:0] shadow_right [hbsd_pkg::MAX_NODES];
  logic [hbsd_pkg::SYM_W-1:0]   shadow_sym   [hbsd_pkg::MAX_NODES];
  logic                         shadow_leaf  [hbsd_pkg::MAX_NODES];
  int unsigned                  shadow_used;
  int unsigned                  shadow_pos;

  // Result words still owed by the decoder, oldest first.
  hbsd_pkg::result_t results_owed [$];

  int fail_count     = 0;
  int words_sent     = 0;
  int reserved_sent  = 0;
  int results_seen   = 0;
  int symbols_owed   = 0;
  int full_hits      = 0;
  int missing_hits   = 0;
  int conflict_hits  = 0;

  // Sender pacing: bursts of words separated by idle gaps, when enabled.
  int burst_left    = 0;
  bit sender_bursty = 1'b1;

  // Receiver stall pattern: an 8-bit ready mask, redrawn whenever rx_phase wraps.
  logic [7:0] rx_mask  = 8'hFF;
  logic [5:0] rx_phase = 6'd0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void owe_result(input logic [7:0] s, input logic v,
                                     input hbsd_pkg::err_t e, input logic l);
    hbsd_pkg::result_t r;
    r.symbol       = s;
    r.symbol_valid = v;
    r.error_code   = e;
    r.last_of_item = l;
    results_owed.insert(results_owed.size(), r);
    if (v) symbols_owed++;
    case (e)
      hbsd_pkg::ERR_FULL:    full_hits++;
      hbsd_pkg::ERR_MISSING: missing_hits++;
      hbsd_pkg::ERR_PREFIX:  conflict_hits++;
      default: ;
    endcase
  endfunction

  function automatic void blank_node(input int unsigned n);
    shadow_left[n]  = '0;
    shadow_right[n] = '0;
    shadow_sym[n]   = '0;
    shadow_leaf[n]  = 1'b0;
  endfunction

  // Walk the shadow tree along a code, growing it as needed; return the error.
  function automatic hbsd_pkg::err_t grow_code_path(input logic [7:0] s,
                                                    input logic [31:0] code,
                                                    input logic [5:0] len_in);
    int unsigned node;
    int unsigned child;
    int unsigned len;
    int unsigned i;
    logic        b;
    node = 0;
    if (len_in == 0) return hbsd_pkg::ERR_PREFIX;
    len = (len_in > hbsd_pkg::MAX_CODE_LEN) ? hbsd_pkg::MAX_CODE_LEN : len_in;
    for (i = len; i > 0; i--) begin
      b = code[i-1];
      // a leaf on the way means this code extends an existing one
      if (shadow_leaf[node]) return hbsd_pkg::ERR_PREFIX;
      child = b ? shadow_right[node] : shadow_left[node];
      if (child == 0 || child >= shadow_used) begin
        if (shadow_used >= hbsd_pkg::MAX_NODES) return hbsd_pkg::ERR_FULL;
        child = shadow_used;
        shadow_used++;
        blank_node(child);
        if (b) shadow_right[node] = child[hbsd_pkg::NODE_AW-1:0];
        else shadow_left[node] = child[hbsd_pkg::NODE_AW-1:0];
      end
      node = child;
    end
    // an inner node cannot become a leaf
    if (shadow_left[node] != 0 || shadow_right[node] != 0) return hbsd_pkg::ERR_PREFIX;
    shadow_leaf[node] = 1'b1;
    shadow_sym[node]  = s;
    return hbsd_pkg::ERR_OK;
  endfunction

  // Work out the result words of one accepted input word.
  function automatic void predict_tree_word(input tree_cmd_t c);
    hbsd_pkg::result_t found [hbsd_pkg::BYTE_BITS];
    int unsigned       node;
    int unsigned       child;
    int unsigned       nb;
    int unsigned       i;
    int                cnt;
    logic              b;
    case (c.op)
      hbsd_pkg::OP_CLEAR: begin
        shadow_used = 1;
        blank_node(0);
        shadow_pos = 0;
        owe_result(8'h00, 1'b0, hbsd_pkg::ERR_OK, 1'b1);
      end
      hbsd_pkg::OP_LOAD: begin
        owe_result(8'h00, 1'b0, grow_code_path(c.sym, c.code, c.len), 1'b1);
      end
      hbsd_pkg::OP_DECODE: begin
        cnt  = 0;
        nb   = (c.nbits > hbsd_pkg::BYTE_BITS) ? hbsd_pkg::BYTE_BITS : c.nbits;
        node = (shadow_pos >= shadow_used) ? 0 : shadow_pos;
        for (i = nb; i > 0; i--) begin
          b     = c.data[i-1];
          child = b ? shadow_right[node] : shadow_left[node];
          if (child == 0 || child >= shadow_used) begin
            // missing child: report once, back to the root, drop the rest
            found[cnt] = '{8'h00, 1'b0, hbsd_pkg::ERR_MISSING, 1'b0};
            cnt++;
            node = 0;
            break;
          end
          node = child;
          if (shadow_leaf[node]) begin
            found[cnt] = '{shadow_sym[node], 1'b1, hbsd_pkg::ERR_OK, 1'b0};
            cnt++;
            node = 0;
          end
        end
        shadow_pos = node;
        if (cnt == 0) begin
          owe_result(8'h00, 1'b0, hbsd_pkg::ERR_OK, 1'b1);
        end else begin
          for (int k = 0; k < cnt; k++)
            owe_result(found[k].symbol, found[k].symbol_valid, found[k].error_code,
                       k == cnt - 1);
        end
      end
      default: ; // reserved operation: taken and dropped without a result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders: unused fields get random junk so every bit toggles.
  // ---------------------------------------------------------------------------

  function automatic tree_cmd_t junk_word(input hbsd_pkg::op_t op);
    tree_cmd_t c;
    c.op    = op;
    c.sym   = 8'($urandom);
    c.code  = $urandom;
    c.len   = 6'($urandom);
    c.data  = 8'($urandom);
    c.nbits = 4'($urandom);
    return c;
  endfunction

  function automatic tree_cmd_t load_word(input logic [7:0] s, input logic [31:0] code,
                                          input logic [5:0] len);
    tree_cmd_t c;
    c      = junk_word(hbsd_pkg::OP_LOAD);
    c.sym  = s;
    c.code = code;
    c.len  = len;
    return c;
  endfunction

  function automatic tree_cmd_t decode_word(input logic [7:0] data, input logic [3:0] nbits);
    tree_cmd_t c;
    c       = junk_word(hbsd_pkg::OP_DECODE);
    c.data  = data;
    c.nbits = nbits;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and checker
  // ---------------------------------------------------------------------------

  // Present one word at the falling edge, hold it until accepted, then predict.
  task automatic send_word(input tree_cmd_t c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (sender_bursty) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      in_port.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_port.operation    = c.op;
    in_port.symbol_value = c.sym;
    in_port.code_word    = c.code;
    in_port.code_length  = c.len;
    in_port.data_byte    = c.data;
    in_port.valid_bits   = c.nbits;
    in_port.valid        = 1'b1;
    do @(posedge clk); while (!in_port.ready);
    words_sent++;
    if (c.op == hbsd_pkg::OP_RSVD) reserved_sent++;
    predict_tree_word(c);
  endtask

  // Drop valid and hold off until every owed result word has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_port.valid = 1'b0;
    burst_left    = 0;
    while (results_owed.size() != 0) @(posedge clk);
  endtask

  // Redraw the ready mask whenever rx_phase wraps: always ready, one in eight, or random.
  always @(negedge clk) begin
    if (rx_phase == 6'd0) begin
      case ($urandom_range(0, 3))
        0: rx_mask = 8'hFF;
        1: rx_mask = 8'h01;
        default: rx_mask = 8'($urandom) | 8'h10;
      endcase
    end
    out_port.ready = rx_mask[rx_phase[2:0]];
    rx_phase       = rx_phase + 6'd1;
  end

  // Compare each taken result word with the oldest owed one, field by field.
  always @(posedge clk) begin : check_results
    hbsd_pkg::result_t want;
    if (rst_n && out_port.valid && out_port.ready) begin
      if (results_owed.size() == 0) begin
        $error("unexpected result word: symbol %02h valid %0b error %0d last %0b",
               out_port.symbol, out_port.symbol_valid, out_port.error_code,
               out_port.last_of_item);
        fail_count++;
      end else begin
        want = results_owed.pop_front();
        results_seen++;
        if (out_port.symbol !== want.symbol) begin
          $error("symbol: expected %02h, got %02h", want.symbol, out_port.symbol);
          fail_count++;
        end
        if (out_port.symbol_valid !== want.symbol_valid) begin
          $error("symbol_valid: expected %0b, got %0b", want.symbol_valid,
                 out_port.symbol_valid);
          fail_count++;
        end
        if (out_port.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_port.error_code);
          fail_count++;
        end
        if (out_port.last_of_item !== want.last_of_item) begin
          $error("last_of_item: expected %0b, got %0b", want.last_of_item,
                 out_port.last_of_item);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every operation and every error but a full tree on a small hand-built tree.
  task automatic test_directed_cases();
    sender_bursty = 1'b1;
    send_word(junk_word(hbsd_pkg::OP_CLEAR));
    send_word(decode_word(8'hA5, 4'd8));                 // empty tree: missing child
    send_word(decode_word(8'h3C, 4'd0));                 // no bits walked
    send_word(load_word(8'h11, 32'hFFFF_FFFF, 6'd0));    // zero length: conflict
    send_word(load_word(8'h41, 32'hFFFF_FFFE, 6'd1));    // '0'
    send_word(load_word(8'h42, 32'h0000_0002, 6'd2));    // '10'
    send_word(load_word(8'h43, 32'hABCD_0003, 6'd2));    // '11'
    send_word(load_word(8'h44, 32'h0000_0002, 6'd2));    // '10' again: overwrite
    send_word(load_word(8'h45, 32'h0000_0001, 6'd1));    // '1' already has children
    send_word(load_word(8'h46, 32'h0000_0002, 6'd3));    // '010' runs through a leaf
    send_word(decode_word(8'h00, 4'd8));                 // eight symbols from one byte
    send_word(decode_word(8'hB5, 4'd8));                 // ends mid-code at '1'
    send_word(decode_word(8'h5B, 4'd1));                 // resume there: '11'
    send_word(decode_word(8'hFF, 4'd15));                // count above eight saturates
    send_word(junk_word(hbsd_pkg::OP_RSVD));
    send_word(junk_word(hbsd_pkg::OP_CLEAR));
    send_word(load_word(8'h5A, 32'hFFFF_FFFF, 6'd63));   // length saturates to 32
    send_word(load_word(8'h33, 32'h0000_0001, 6'd33));
    for (int k = 0; k < 4; k++)
      send_word(decode_word(8'hFF, 4'd8));               // symbol on the fourth byte
    send_word(decode_word(8'h7F, 4'd8));                 // missing child at depth two
    send_word(load_word(8'h77, 32'h0000_0000, 6'd1));    // inner node: conflict
    wait_drained();
  endtask

  // Fill the node store with long random codes until it reports full twice or 60 loads are sent.
  task automatic test_tree_full();
    logic [31:0] first_code;
    int          full_base;
    int          loads;
    sender_bursty = 1'b0;
    send_word(junk_word(hbsd_pkg::OP_CLEAR));
    first_code = $urandom;
    send_word(load_word(8'hC3, first_code, 6'd32));
    full_base = full_hits;
    loads     = 0;
    while (full_hits - full_base < 2 && loads < 60) begin
      send_word(load_word(8'($urandom), $urandom,
                          ($urandom_range(0, 1) != 0) ? 6'd32 : 6'($urandom_range(32, 63))));
      loads++;
    end
    // walk the first code on a full tree, then some stray bytes
    for (int k = 3; k >= 0; k--)
      send_word(decode_word(first_code[k*8 +: 8], 4'd8));
    send_word(decode_word(8'($urandom), 4'd8));
    send_word(decode_word(8'($urandom), 4'd8));
    // a clear must give a usable tree again
    send_word(junk_word(hbsd_pkg::OP_CLEAR));
    send_word(load_word(8'h9E, 32'h0000_0001, 6'd1));
    send_word(decode_word(8'h81, 4'd1));
    sender_bursty = 1'b1;
  endtask

  // Random prefix-free code sets loaded and then fed with encoded byte streams,
  // mixed with stray loads, stray bytes and reserved words.
  task automatic test_random_streams();
    logic [31:0] cw [16];
    int          cl [16];
    logic [7:0]  cs [16];
    logic        bitq [$];
    logic [7:0]  data;
    int          base;
    int          n;
    int          target;
    int          maxlen;
    int          idx;
    int          start;
    int          skip;
    int          nb;
    int          i;
    base = words_sent - reserved_sent;
    while ((words_sent - reserved_sent) - base < 60) begin
      sender_bursty = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        7: send_word(decode_word(8'($urandom), 4'($urandom)));
        8: send_word(load_word(8'($urandom), $urandom, 6'($urandom)));
        9: send_word(junk_word(hbsd_pkg::OP_RSVD));
        default: begin
          // split leaves at random until the code set is big enough
          target = $urandom_range(2, 12);
          maxlen = ($urandom_range(0, 3) == 0) ? 16 : 5;
          n      = 1;
          cw[0]  = '0;
          cl[0]  = 0;
          while (n < target) begin
            idx = ($urandom_range(0, 1) != 0) ? n - 1 : $urandom_range(0, n - 1);
            if (cl[idx] < maxlen) begin
              cw[n]   = {cw[idx][30:0], 1'b1};
              cl[n]   = cl[idx] + 1;
              cw[idx] = {cw[idx][30:0], 1'b0};
              cl[idx] = cl[idx] + 1;
              n++;
            end
          end
          for (int k = 0; k < n; k++) cs[k] = 8'($urandom);
          // mostly start from an empty tree; sometimes stack on the old one
          if ($urandom_range(0, 7) != 0) send_word(junk_word(hbsd_pkg::OP_CLEAR));
          // leave one code out now and then so decodes can hit a missing child
          skip  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
          start = $urandom_range(0, n - 1);
          for (int k = 0; k < n; k++) begin
            i = (start + k) % n;
            if (i != skip)
              send_word(load_word(cs[i], cw[i] | ($urandom << cl[i]), 6'(cl[i])));
          end
          // encode random symbols, MSB first, and send them a byte at a time
          bitq.delete();
          target = 8 * $urandom_range(1, 5);
          while (bitq.size() < target) begin
            i = $urandom_range(0, n - 1);
            for (int k = cl[i] - 1; k >= 0; k--) bitq.insert(bitq.size(), cw[i][k]);
          end
          while (bitq.size() != 0) begin
            nb   = (bitq.size() > 8) ? 8 : bitq.size();
            data = 8'($urandom);
            for (int k = nb - 1; k >= 0; k--) data[k] = bitq.pop_front();
            send_word(decode_word(data, 4'(nb)));
          end
          if ($urandom_range(0, 4) == 0) wait_drained();
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // drive every decoder input to a known value from time zero
    in_port.valid        = 1'b0;
    in_port.operation    = hbsd_pkg::OP_CLEAR;
    in_port.symbol_value = '0;
    in_port.code_word    = '0;
    in_port.code_length  = '0;
    in_port.data_byte    = '0;
    in_port.valid_bits   = '0;
    out_port.ready       = 1'b0;
    // shadow state as after reset
    for (int k = 0; k < hbsd_pkg::MAX_NODES; k++) blank_node(k);
    shadow_used = 1;
    shadow_pos  = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_tree_full();
    test_random_streams();

    // drain: every owed word, then enough cycles to catch any stray extra
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input words (%0d reserved) and checked %0d result words:",
             words_sent, reserved_sent, results_seen);
    $display("  %0d symbols, %0d tree full, %0d missing child, %0d prefix conflict",
             symbols_owed, full_hits, missing_hits, conflict_hits);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard limit well above the slowest correct run.
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
